// File: hdl/egas_pkg.sv
// ----------------------------------------------------------------------------
// egas_pkg
// shared types, codes and the microprogram of the epsilon-greedy arm selector
// ----------------------------------------------------------------------------
package egas_pkg;

  // register indexes on the configuration channel
  localparam int unsigned CFG_IDX_W             = 8;
  localparam int unsigned CFG_DATA_W            = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_ADAPT_ENABLE      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE_THRESHOLD = 8'd1;

  localparam int unsigned THRESH_W     = 17;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 17'd6554;
  localparam int unsigned CNT32_W      = 32;

  // remainder unit: digits of the random word taken per cycle
  localparam int unsigned MOD_DIGIT    = 4;
  localparam int unsigned MOD_STEPS    = 32 / MOD_DIGIT;

  // partial product chunk of the shared multiplier
  localparam int unsigned CHUNK_W      = 32;

  typedef struct packed {
    logic        opcode;
    logic [15:0] reward;
    logic [15:0] walk_cost;
    logic [15:0] rand_fraction;
    logic [31:0] rand_word;
  } in_t;

  typedef struct packed {
    logic [1:0] selected_arm;
    logic       explored;
  } out_t;

  localparam logic OPC_FEEDBACK = 1'b0;
  localparam logic OPC_CHOOSE   = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT_SCAN,
    OP_READ_I,
    OP_MUL,
    OP_SAVE,
    OP_TAKE,
    OP_NEXT,
    OP_COMMIT,
    OP_MOD,
    OP_EXPLORE,
    OP_LOAD_CUR,
    OP_FB_WRITE,
    OP_RESULT
  } op_t;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_NEVER,
    C_NOT_START,
    C_FEEDBACK,
    C_NOT_ADAPT,
    C_EXPLORE,
    C_ZERO_COST,
    C_PULL_ZERO,
    C_NOT_FOUND,
    C_LOOP_BUSY,
    C_CMP_GT,
    C_CMP_NE,
    C_CMP_GE,
    C_NOT_LAST
  } cond_t;

  // operand pairs of the multiplier
  typedef enum logic [1:0] {
    MUL_RI_CB,   // reward of candidate times cost of best
    MUL_RB_CI,   // reward of best times cost of candidate
    MUL_CI_NB,   // cost of candidate times pulls of best
    MUL_CB_NI    // cost of best times pulls of candidate
  } mul_sel_t;

  localparam int unsigned STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    op_t      op;
    cond_t    cond;
    mul_sel_t sel;
    step_t    target;
  } uword_t;

  typedef struct packed {
    logic is_choose;
    logic adapt;
    logic explore;
    logic zero_cost;
    logic pull_zero;
    logic found;
    logic loop_done;
    logic cmp_gt;
    logic cmp_eq;
    logic last_idx;
  } dp_stat_t;

  // microprogram addresses
  localparam step_t S_IDLE     = 5'd0;
  localparam step_t S_DISPATCH = 5'd1;
  localparam step_t S_CHOOSE   = 5'd2;
  localparam step_t S_PICK     = 5'd3;
  localparam step_t S_INIT     = 5'd4;
  localparam step_t S_LOOP     = 5'd5;
  localparam step_t S_SKIP     = 5'd6;
  localparam step_t S_FIRST    = 5'd7;
  localparam step_t S_MUL_A    = 5'd8;
  localparam step_t S_SAVE_A   = 5'd9;
  localparam step_t S_MUL_B    = 5'd10;
  localparam step_t S_RATIO_GT = 5'd11;
  localparam step_t S_RATIO_NE = 5'd12;
  localparam step_t S_MUL_C    = 5'd13;
  localparam step_t S_SAVE_C   = 5'd14;
  localparam step_t S_MUL_D    = 5'd15;
  localparam step_t S_AVG_GE   = 5'd16;
  localparam step_t S_TAKE     = 5'd17;
  localparam step_t S_NEXT     = 5'd18;
  localparam step_t S_COMMIT   = 5'd19;
  localparam step_t S_EXPL     = 5'd20;
  localparam step_t S_EXPL_SET = 5'd21;
  localparam step_t S_FB       = 5'd22;
  localparam step_t S_FB_WR    = 5'd23;
  localparam step_t S_RES      = 5'd24;

  function automatic uword_t uw(input op_t op, input cond_t cond, input mul_sel_t sel,
                                input step_t target);
    uword_t w;
    w.op     = op;
    w.cond   = cond;
    w.sel    = sel;
    w.target = target;
    return w;
  endfunction

  // control store
  function automatic uword_t ucode(input step_t step);
    uword_t w;
    unique case (step)
      S_IDLE:     w = uw(OP_NONE,      C_NOT_START, MUL_RI_CB, S_IDLE);
      S_DISPATCH: w = uw(OP_NONE,      C_FEEDBACK,  MUL_RI_CB, S_FB);
      S_CHOOSE:   w = uw(OP_NONE,      C_NOT_ADAPT, MUL_RI_CB, S_RES);
      S_PICK:     w = uw(OP_NONE,      C_EXPLORE,   MUL_RI_CB, S_EXPL);
      S_INIT:     w = uw(OP_INIT_SCAN, C_NEVER,     MUL_RI_CB, S_IDLE);
      S_LOOP:     w = uw(OP_READ_I,    C_NEVER,     MUL_RI_CB, S_IDLE);
      S_SKIP:     w = uw(OP_NONE,      C_PULL_ZERO, MUL_RI_CB, S_NEXT);
      S_FIRST:    w = uw(OP_NONE,      C_NOT_FOUND, MUL_RI_CB, S_TAKE);
      S_MUL_A:    w = uw(OP_MUL,       C_LOOP_BUSY, MUL_RI_CB, S_MUL_A);
      S_SAVE_A:   w = uw(OP_SAVE,      C_NEVER,     MUL_RI_CB, S_IDLE);
      S_MUL_B:    w = uw(OP_MUL,       C_LOOP_BUSY, MUL_RB_CI, S_MUL_B);
      S_RATIO_GT: w = uw(OP_NONE,      C_CMP_GT,    MUL_RI_CB, S_TAKE);
      S_RATIO_NE: w = uw(OP_NONE,      C_CMP_NE,    MUL_RI_CB, S_NEXT);
      S_MUL_C:    w = uw(OP_MUL,       C_LOOP_BUSY, MUL_CI_NB, S_MUL_C);
      S_SAVE_C:   w = uw(OP_SAVE,      C_NEVER,     MUL_RI_CB, S_IDLE);
      S_MUL_D:    w = uw(OP_MUL,       C_LOOP_BUSY, MUL_CB_NI, S_MUL_D);
      S_AVG_GE:   w = uw(OP_NONE,      C_CMP_GE,    MUL_RI_CB, S_NEXT);
      S_TAKE:     w = uw(OP_TAKE,      C_NEVER,     MUL_RI_CB, S_IDLE);
      S_NEXT:     w = uw(OP_NEXT,      C_NOT_LAST,  MUL_RI_CB, S_LOOP);
      S_COMMIT:   w = uw(OP_COMMIT,    C_ALWAYS,    MUL_RI_CB, S_RES);
      S_EXPL:     w = uw(OP_MOD,       C_LOOP_BUSY, MUL_RI_CB, S_EXPL);
      S_EXPL_SET: w = uw(OP_EXPLORE,   C_ALWAYS,    MUL_RI_CB, S_RES);
      S_FB:       w = uw(OP_LOAD_CUR,  C_ZERO_COST, MUL_RI_CB, S_RES);
      S_FB_WR:    w = uw(OP_FB_WRITE,  C_NEVER,     MUL_RI_CB, S_IDLE);
      S_RES:      w = uw(OP_RESULT,    C_ALWAYS,    MUL_RI_CB, S_IDLE);
      default:    w = uw(OP_NONE,      C_ALWAYS,    MUL_RI_CB, S_IDLE);
    endcase
    return w;
  endfunction

endpackage

// File: hdl/epsilon_greedy_arm_selector.sv
// ----------------------------------------------------------------------------
// epsilon_greedy_arm_selector
// epsilon-greedy bandit over NUM_ARMS arms, run by a small microprogram
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; exactly one result
// follows, shown for a single cycle with result_valid high, and it must be
// captured then because the receiver cannot stall it. The block handles one
// transaction at a time and raises busy until the result has gone out.
// Feedback with a zero walk cost skips the update of the arm statistics.
// An exploring choose waits on the remainder unit that reduces the 32-bit
// random word four bits per cycle. An exploiting choose walks the arms one
// by one through a single 32x32 multiplier, which takes one partial product
// for sums up to 32 bits and four for sums up to 64 bits; an arm whose ratio
// ties the best so far also has its average compared. Configuration writes
// are always ready and should only be made while busy is low.
// ----------------------------------------------------------------------------
module epsilon_greedy_arm_selector #(
  parameter int NUM_ARMS  = 3,
  parameter int SUM_WIDTH = 40
) (
  input  logic                               clk,
  input  logic                               rst,
  // item channel
  input  logic                               start,
  output logic                               busy,
  input  egas_pkg::in_t                      item,
  // result channel
  output logic                               result_valid,
  output egas_pkg::out_t                     result,
  // configuration channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [egas_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [egas_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // configuration registers
  logic                              adapt_enable;
  logic [egas_pkg::THRESH_W-1:0]     explore_threshold;

  egas_pkg::uword_t   uword;
  egas_pkg::dp_stat_t stat;
  logic               accept;

  // a transaction is taken only while the sequencer waits in its idle step
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // result strobe comes straight from the control word of the final step
  assign result_valid = (uword.op == egas_pkg::OP_RESULT);

  always_ff @(posedge clk) begin
    if (rst) begin
      adapt_enable      <= 1'b0;
      explore_threshold <= egas_pkg::THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      // unknown indexes are dropped
      case (cfg_index)
        egas_pkg::CFG_ADAPT_ENABLE:      adapt_enable      <= cfg_data[0];
        egas_pkg::CFG_EXPLORE_THRESHOLD: explore_threshold <=
                                           cfg_data[egas_pkg::THRESH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // microprogram sequencer: step counter, control store, jump conditions
  egas_useq u_useq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .uword (uword),
    .busy  (busy)
  );

  // datapath: arm statistics, scan registers, multiplier, remainder unit
  egas_dpath #(
    .NUM_ARMS  (NUM_ARMS),
    .SUM_WIDTH (SUM_WIDTH)
  ) u_dpath (
    .clk               (clk),
    .rst               (rst),
    .accept            (accept),
    .item              (item),
    .adapt_enable      (adapt_enable),
    .explore_threshold (explore_threshold),
    .uword             (uword),
    .stat              (stat),
    .result            (result)
  );

endmodule

// File: hdl/egas_useq.sv
// ----------------------------------------------------------------------------
// egas_useq
// step counter, control store lookup and jump logic
// ----------------------------------------------------------------------------
module egas_useq (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  egas_pkg::dp_stat_t stat,
  output egas_pkg::uword_t  uword,
  output logic              busy
);

  egas_pkg::step_t step;
  egas_pkg::step_t step_next;
  logic            take_jump;

  assign uword = egas_pkg::ucode(step);
  assign busy  = (step != egas_pkg::S_IDLE);

  always_comb begin
    unique case (uword.cond)
      egas_pkg::C_ALWAYS:    take_jump = 1'b1;
      egas_pkg::C_NEVER:     take_jump = 1'b0;
      egas_pkg::C_NOT_START: take_jump = !start;
      egas_pkg::C_FEEDBACK:  take_jump = !stat.is_choose;
      egas_pkg::C_NOT_ADAPT: take_jump = !stat.adapt;
      egas_pkg::C_EXPLORE:   take_jump = stat.explore;
      egas_pkg::C_ZERO_COST: take_jump = stat.zero_cost;
      egas_pkg::C_PULL_ZERO: take_jump = stat.pull_zero;
      egas_pkg::C_NOT_FOUND: take_jump = !stat.found;
      egas_pkg::C_LOOP_BUSY: take_jump = !stat.loop_done;
      egas_pkg::C_CMP_GT:    take_jump = stat.cmp_gt;
      egas_pkg::C_CMP_NE:    take_jump = !stat.cmp_eq;
      egas_pkg::C_CMP_GE:    take_jump = stat.cmp_gt | stat.cmp_eq;
      egas_pkg::C_NOT_LAST:  take_jump = !stat.last_idx;
      default:               take_jump = 1'b1;
    endcase
  end

  always_comb begin
    if (take_jump) begin
      step_next = uword.target;
    end else begin
      step_next = step + egas_pkg::step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= egas_pkg::S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

// File: hdl/egas_dpath.sv
// ----------------------------------------------------------------------------
// egas_dpath
// arm statistics, operand registers, shared multiplier and remainder unit
// ----------------------------------------------------------------------------
module egas_dpath #(
  parameter int NUM_ARMS  = 3,
  parameter int SUM_WIDTH = 40
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  egas_pkg::in_t                     item,
  input  logic                              adapt_enable,
  input  logic [egas_pkg::THRESH_W-1:0]     explore_threshold,
  input  egas_pkg::uword_t                  uword,
  output egas_pkg::dp_stat_t                stat,
  output egas_pkg::out_t                    result
);

  localparam int AW    = $clog2(NUM_ARMS);
  localparam int NCH   = (SUM_WIDTH + egas_pkg::CHUNK_W - 1) / egas_pkg::CHUNK_W;
  localparam int PW    = NCH * egas_pkg::CHUNK_W;
  localparam int NPP   = NCH * NCH;
  localparam int LOOPMAX = (NPP > egas_pkg::MOD_STEPS - 1) ? NPP : egas_pkg::MOD_STEPS - 1;
  localparam int CNT_W = $clog2(LOOPMAX + 1);
  localparam int SH_W  = $clog2(2 * NCH);
  localparam int CW    = egas_pkg::CNT32_W;
  localparam logic [AW:0]   ARMS     = (AW + 1)'(NUM_ARMS);
  localparam logic [AW-1:0] LAST_ARM = AW'(NUM_ARMS - 1);

  // per-arm statistics
  logic [SUM_WIDTH-1:0] reward_sums [NUM_ARMS];
  logic [SUM_WIDTH-1:0] cost_sums   [NUM_ARMS];
  logic [CW-1:0]        pull_counts [NUM_ARMS];
  logic [CW-1:0]        sample_total;

  logic [AW-1:0]        cur;
  logic                 explored;
  egas_pkg::in_t        item_q;

  // scan state
  logic [AW-1:0]        idx;
  logic [AW-1:0]        best;
  logic                 found;
  logic [SUM_WIDTH-1:0] ri, ci, rb, cb;
  logic [CW-1:0]        ni, nb;

  // multiplier and remainder loop
  logic [CNT_W-1:0]     cnt;
  logic [2*CHUNK_WL-1:0] pp;
  logic [SH_W-1:0]      pp_sh;
  logic [2*PW-1:0]      acc;
  logic [2*PW-1:0]      prod;
  logic [AW-1:0]        rem;
  logic [31:0]          wrd;

  localparam int CHUNK_WL = egas_pkg::CHUNK_W;

  logic [AW-1:0]        rd_addr;
  logic [PW-1:0]        x_op, y_op;
  logic [CNT_W-1:0]     ka, kb;
  logic [CHUNK_WL-1:0]  x_chunk, y_chunk;
  logic                 loop_done;
  logic [AW:0]          mod_r;
  logic [SUM_WIDTH:0]   rsum, csum;
  logic [SUM_WIDTH-1:0] rsat, csat;
  logic [CW-1:0]        ninc, tinc;

  assign rd_addr = (uword.op == egas_pkg::OP_READ_I) ? idx : cur;

  always_comb begin
    unique case (uword.sel)
      egas_pkg::MUL_RI_CB: begin
        x_op = PW'(ri);
        y_op = PW'(cb);
      end
      egas_pkg::MUL_RB_CI: begin
        x_op = PW'(rb);
        y_op = PW'(ci);
      end
      egas_pkg::MUL_CI_NB: begin
        x_op = PW'(ci);
        y_op = PW'(nb);
      end
      egas_pkg::MUL_CB_NI: begin
        x_op = PW'(cb);
        y_op = PW'(ni);
      end
      default: begin
        x_op = '0;
        y_op = '0;
      end
    endcase
  end

  // chunk pair for the partial product of this cycle
  assign ka      = CNT_W'(cnt % NCH);
  assign kb      = CNT_W'(cnt / NCH);
  assign x_chunk = CHUNK_WL'(x_op >> (CHUNK_WL * ka));
  assign y_chunk = CHUNK_WL'(y_op >> (CHUNK_WL * kb));

  assign loop_done = ((uword.op == egas_pkg::OP_MUL) && (cnt == CNT_W'(NPP))) ||
                     ((uword.op == egas_pkg::OP_MOD) &&
                      (cnt == CNT_W'(egas_pkg::MOD_STEPS - 1)));

  // four bits of rand_word reduced mod NUM_ARMS per cycle
  always_comb begin
    mod_r = {1'b0, rem};
    for (int b = egas_pkg::MOD_DIGIT - 1; b >= 0; b--) begin
      mod_r = {mod_r[AW-1:0], wrd[32 - egas_pkg::MOD_DIGIT + b]};
      if (mod_r >= ARMS) begin
        mod_r = mod_r - ARMS;
      end
    end
  end

  // saturating updates for feedback
  assign rsum = {1'b0, ri} + (SUM_WIDTH + 1)'(item_q.reward);
  assign csum = {1'b0, ci} + (SUM_WIDTH + 1)'(item_q.walk_cost);
  assign rsat = rsum[SUM_WIDTH] ? '1 : rsum[SUM_WIDTH-1:0];
  assign csat = csum[SUM_WIDTH] ? '1 : csum[SUM_WIDTH-1:0];
  assign ninc = (&ni) ? ni : ni + CW'(1);
  assign tinc = (&sample_total) ? sample_total : sample_total + CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < NUM_ARMS; a++) begin
        reward_sums[a] <= '0;
        cost_sums[a]   <= '0;
        pull_counts[a] <= '0;
      end
      sample_total <= '0;
      cur          <= '0;
      explored     <= 1'b0;
      found        <= 1'b0;
      cnt          <= '0;
    end else begin
      if (accept) begin
        explored <= 1'b0;
        cnt      <= '0;
      end
      if ((uword.op == egas_pkg::OP_MUL) || (uword.op == egas_pkg::OP_MOD)) begin
        cnt <= loop_done ? '0 : cnt + CNT_W'(1);
      end
      case (uword.op)
        egas_pkg::OP_INIT_SCAN: found <= 1'b0;
        egas_pkg::OP_TAKE:      found <= 1'b1;
        egas_pkg::OP_COMMIT:    cur   <= best;
        egas_pkg::OP_EXPLORE: begin
          cur      <= rem;
          explored <= 1'b1;
        end
        egas_pkg::OP_FB_WRITE: begin
          reward_sums[cur] <= rsat;
          cost_sums[cur]   <= csat;
          pull_counts[cur] <= ninc;
          sample_total     <= tinc;
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
      wrd    <= item.rand_word;
      rem    <= '0;
    end
    case (uword.op)
      egas_pkg::OP_INIT_SCAN: begin
        idx  <= '0;
        best <= cur;
      end
      egas_pkg::OP_READ_I, egas_pkg::OP_LOAD_CUR: begin
        ri <= reward_sums[rd_addr];
        ci <= cost_sums[rd_addr];
        ni <= pull_counts[rd_addr];
      end
      egas_pkg::OP_TAKE: begin
        best <= idx;
        rb   <= ri;
        cb   <= ci;
        nb   <= ni;
      end
      egas_pkg::OP_NEXT: idx <= idx + AW'(1);
      egas_pkg::OP_SAVE: prod <= acc;
      egas_pkg::OP_MUL: begin
        pp    <= x_chunk * y_chunk;
        pp_sh <= SH_W'(ka + kb);
        if (cnt == '0) begin
          acc <= '0;
        end else begin
          acc <= acc + ((2 * PW)'(pp) << (CHUNK_WL * pp_sh));
        end
      end
      egas_pkg::OP_MOD: begin
        rem <= mod_r[AW-1:0];
        wrd <= wrd << egas_pkg::MOD_DIGIT;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat.is_choose = (item_q.opcode == egas_pkg::OPC_CHOOSE);
    stat.adapt     = adapt_enable;
    stat.explore   = ({1'b0, item_q.rand_fraction} < explore_threshold) ||
                     (sample_total == '0);
    stat.zero_cost = (item_q.walk_cost == '0);
    stat.pull_zero = (ni == '0);
    stat.found     = found;
    stat.loop_done = loop_done;
    stat.cmp_gt    = (prod > acc);
    stat.cmp_eq    = (prod == acc);
    stat.last_idx  = (idx == LAST_ARM);
  end

  assign result.selected_arm = 2'(cur);
  assign result.explored     = explored;

endmodule
